>>> rtl/blvr_pkg.sv
// Shared types and constants for the bounded value list.
`default_nettype none
package blvr_pkg;

    // List capacity and derived widths
    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SIZE_W = 5;
    localparam int VAL_W  = 32;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIND   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Front value reported for an empty list
    localparam logic signed [VAL_W-1:0] FRONT_NONE = {VAL_W{1'b1}};

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [VAL_W-1:0] operand_value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic                    found;
        logic signed [VAL_W-1:0] front_value;
        logic                    front_valid;
        logic [SIZE_W-1:0]       size_now;
    } rsp_t;

    // Engine status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } eng_stat_t;

endpackage
`default_nettype wire

>>> rtl/blvr_engine.sv
// List storage and sequencer: one compare/copy step per stored entry.
`default_nettype none
module blvr_engine (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire blvr_pkg::req_t      cmd,
    input  wire logic                take,
    output blvr_pkg::eng_stat_t      stat,
    output blvr_pkg::rsp_t           result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FRONT,
        S_FWAIT,
        S_DONE
    } state_t;

    localparam logic [blvr_pkg::CNT_W-1:0] CNT_ONE  = blvr_pkg::CNT_W'(1);
    localparam logic [blvr_pkg::CNT_W-1:0] CNT_FULL = blvr_pkg::CNT_W'(blvr_pkg::DEPTH);

    // Storage: one write port, one registered read port
    logic [blvr_pkg::VAL_W-1:0] mem [blvr_pkg::DEPTH];
    logic [blvr_pkg::VAL_W-1:0] rd_data_reg;

    logic                        mem_we;
    logic [blvr_pkg::ADDR_W-1:0] wr_addr;
    logic [blvr_pkg::VAL_W-1:0]  wr_data;
    logic                        rd_en;
    logic [blvr_pkg::ADDR_W-1:0] rd_addr;

    state_t                             state_reg,  state_next;
    logic [blvr_pkg::CNT_W-1:0]         count_reg,  count_next;
    logic [blvr_pkg::CNT_W-1:0]         kept_reg,   kept_next;
    logic [blvr_pkg::CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                               pend_reg,   pend_next;
    logic [blvr_pkg::ACT_W-1:0]         act_reg,    act_next;
    logic signed [blvr_pkg::VAL_W-1:0]  val_reg,    val_next;
    logic [blvr_pkg::STAT_W-1:0]        status_reg, status_next;
    logic                               found_reg,  found_next;
    logic signed [blvr_pkg::VAL_W-1:0]  front_reg,  front_next;
    logic                               fvalid_reg, fvalid_next;

    logic [blvr_pkg::CNT_W-1:0]               count_m1;
    logic                                     match;
    logic [blvr_pkg::CNT_W+blvr_pkg::SIZE_W-1:0] size_wide;

    assign count_m1 = count_reg - CNT_ONE;
    assign match    = (rd_data_reg == val_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        kept_next   = kept_reg;
        rd_idx_next = rd_idx_reg;
        pend_next   = pend_reg;
        act_next    = act_reg;
        val_next    = val_reg;
        status_next = status_reg;
        found_next  = found_reg;
        front_next  = front_reg;
        fvalid_next = fvalid_reg;
        mem_we      = 1'b0;
        wr_addr     = count_reg[blvr_pkg::ADDR_W-1:0];
        wr_data     = cmd.operand_value;
        rd_en       = 1'b0;
        rd_addr     = rd_idx_reg[blvr_pkg::ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next    = cmd.action;
                    val_next    = cmd.operand_value;
                    status_next = blvr_pkg::ST_OK;
                    found_next  = 1'b0;
                    state_next  = S_FRONT;
                    unique case (cmd.action)
                        blvr_pkg::ACT_PUSH:
                        begin
                            if (count_reg == CNT_FULL)
                            begin
                                status_next = blvr_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        blvr_pkg::ACT_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = blvr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_m1;
                            end
                        end
                        blvr_pkg::ACT_REMOVE, blvr_pkg::ACT_FIND:
                        begin
                            rd_idx_next = '0;
                            kept_next   = '0;
                            pend_next   = 1'b0;
                            state_next  = S_WALK;
                        end
                        blvr_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // read only, and unused codes
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // Compare the entry read last cycle while the next one is fetched.
                if (pend_reg)
                begin
                    if ((act_reg == blvr_pkg::ACT_REMOVE) && !match)
                    begin
                        mem_we    = 1'b1;
                        wr_addr   = kept_reg[blvr_pkg::ADDR_W-1:0];
                        wr_data   = rd_data_reg;
                        kept_next = kept_reg + CNT_ONE;
                    end
                    if ((act_reg == blvr_pkg::ACT_FIND) && match)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (rd_idx_reg < count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_ONE;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (act_reg == blvr_pkg::ACT_REMOVE)
                        begin
                            count_next = kept_reg;
                        end
                        state_next = S_FRONT;
                    end
                end
            end
            S_FRONT:
            begin
                if (count_reg == '0)
                begin
                    front_next  = blvr_pkg::FRONT_NONE;
                    fvalid_next = 1'b0;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = count_m1[blvr_pkg::ADDR_W-1:0];
                    state_next = S_FWAIT;
                end
            end
            S_FWAIT:
            begin
                front_next  = rd_data_reg;
                fvalid_next = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kept_reg   <= kept_next;
        rd_idx_reg <= rd_idx_next;
        act_reg    <= act_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        front_reg  <= front_next;
        fvalid_reg <= fvalid_next;
    end

    assign size_wide = {{blvr_pkg::SIZE_W{1'b0}}, count_reg};

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);

    assign result.status      = status_reg;
    assign result.found       = found_reg;
    assign result.front_value = front_reg;
    assign result.front_valid = fvalid_reg;
    assign result.size_now    = size_wide[blvr_pkg::SIZE_W-1:0];

endmodule
`default_nettype wire

>>> rtl/bounded_list_with_value_removal_top.sv
// Top level of the bounded value list: request intake and result register.
//
//  channel | valid     | stall     | payload | carries
//  --------+-----------+-----------+---------+----------------------------------
//  request | req_valid | req_stall | req     | action, operand_value
//  result  | rsp_valid | rsp_stall | rsp     | status, found, front, valid, size
//
// Push, pop, clear and read-only: S_FRONT, S_FWAIT, S_DONE; no S_FWAIT if the list ends empty.
// Remove and find walk the stored entries through the single read port, one per cycle,
// pipelined with the compare, then go on to S_FRONT like the other actions.
// One request is in work at a time; req_stall stays high until its result moves into
// the output register. A result held there by rsp_stall lets the next request in.
// Reset clears the entry count and handshake state; list storage is not reset.
`default_nettype none
module bounded_list_with_value_removal_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire blvr_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output blvr_pkg::rsp_t      rsp
);

    blvr_pkg::eng_stat_t eng_stat;
    blvr_pkg::rsp_t      eng_result;

    logic           start;
    logic           take;
    logic           rsp_valid_reg, rsp_valid_next;
    blvr_pkg::rsp_t rsp_reg;

    // A request enters only while the sequencer is idle.
    assign req_stall = eng_stat.busy;
    assign start     = req_valid && !eng_stat.busy;

    // Move a finished result into the output register once it is free.
    assign take = eng_stat.done && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    blvr_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (req),
        .take   (take),
        .stat   (eng_stat),
        .result (eng_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= eng_result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire
